// ===== rtl/hgpg_pkg.sv =====
package hgpg_pkg;

    // Largest frame dimension; effective width and height clamp to it
    localparam int unsigned MAX_DIM = 4096;

    // Field and register widths
    localparam int COORD_W     = 12;
    localparam int DIM_W       = $clog2(MAX_DIM) + 1;
    localparam int PITCH_W     = 14;
    localparam int OFFSET_W    = 27;
    localparam int COLOR_W     = 8;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_INDEX_W = 2;

    // Divider sizing: hue quotient 0..359, value quotient 0..254
    localparam int HUE_Q_W    = 9;
    localparam int VAL_Q_W    = 8;
    localparam int HUE_N_W    = 21;
    localparam int VAL_N_W    = 20;
    localparam int DIV_STAGES = HUE_Q_W;

    // Row product y*pitch
    localparam int ROW_W = COORD_W + PITCH_W;

    // Color ramp: v*k fits 14 bits, divide by 60 through a reciprocal
    localparam int RAMP_K_W    = 6;
    localparam int RAMP_N_W    = COLOR_W + RAMP_K_W;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 15;
    localparam int PROD_W      = RAMP_N_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_60 = 15'd17477;

    localparam int HUE_SPAN = 360;
    localparam int VAL_MAX  = 255;
    localparam int SEG_1    = 60;
    localparam int SEG_2    = 120;
    localparam int SEG_3    = 180;
    localparam int SEG_4    = 240;
    localparam int SEG_5    = 300;

    // Register reset values
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
    localparam logic [PITCH_W-1:0] PITCH_RESET  = 14'd640;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_LINE_PITCH   = 2'd2
    } cfg_reg_t;

    // Hue segments: which channel is full, which ramps, which is off
    typedef enum logic [2:0] {
        SEG_RED_GREEN_UP,
        SEG_GREEN_RED_DOWN,
        SEG_GREEN_BLUE_UP,
        SEG_BLUE_GREEN_DOWN,
        SEG_BLUE_RED_UP,
        SEG_RED_BLUE_DOWN
    } seg_t;

    // Clamp a dimension register to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

// ===== rtl/hue_gradient_pixel_generator.sv =====
// Channel   Handshake                     Payload
// s_        s_valid / s_ready             s_pixel_x, s_pixel_y
// m_        m_valid / m_ready             m_byte_offset, m_red, m_green, m_blue
// cfg_      cfg_wr_en (no wait)           cfg_index, cfg_wr_data
//
// One pixel per clock while the output is not stalled; fifteen register stages, most
// of them the nine restoring divider stages (one quotient bit per stage; the value
// divider uses the last eight).
// Reset clears all valid bits and loads width 640, height 480, pitch 640.
// m_ready low with a result held freezes the pipeline; a one-beat skid register at
// the input takes one more beat while the pipeline is frozen.
module hue_gradient_pixel_generator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [hgpg_pkg::COORD_W-1:0]       s_pixel_x,
    input  logic [hgpg_pkg::COORD_W-1:0]       s_pixel_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [hgpg_pkg::OFFSET_W-1:0]      m_byte_offset,
    output logic [hgpg_pkg::COLOR_W-1:0]       m_red,
    output logic [hgpg_pkg::COLOR_W-1:0]       m_green,
    output logic [hgpg_pkg::COLOR_W-1:0]       m_blue,
    input  logic                               cfg_wr_en,
    input  logic [hgpg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hgpg_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import hgpg_pkg::*;

    // Configuration registers
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [PITCH_W-1:0] line_pitch_reg;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;

    // Input skid
    logic               skid_valid_reg;
    logic [COORD_W-1:0] skid_x_reg;
    logic [COORD_W-1:0] skid_y_reg;
    logic               src_valid;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic               en;

    // Stage 1: clamped coordinates
    logic               s1_valid_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    logic [COORD_W-1:0] s1_x_next;
    logic [COORD_W-1:0] s1_y_next;

    // Stage 2: dividends and row product
    logic               s2_valid_reg;
    logic [HUE_N_W-1:0] s2_hn_reg;
    logic [VAL_N_W-1:0] s2_vn_reg;
    logic [ROW_W-1:0]   s2_row_reg;
    logic [COORD_W-1:0] s2_x_reg;
    logic [ROW_W-1:0]   row_sum;

    // Divider stages
    logic                d_valid_reg [DIV_STAGES];
    logic [HUE_N_W-1:0]  d_rem_h_reg [DIV_STAGES];
    logic [HUE_Q_W-1:0]  d_q_h_reg   [DIV_STAGES];
    logic [VAL_N_W-1:0]  d_rem_v_reg [DIV_STAGES];
    logic [VAL_Q_W-1:0]  d_q_v_reg   [DIV_STAGES];
    logic [OFFSET_W-1:0] d_off_reg   [DIV_STAGES];
    logic [HUE_N_W-1:0]  d_rem_h_next [DIV_STAGES];
    logic [HUE_Q_W-1:0]  d_q_h_next   [DIV_STAGES];
    logic [VAL_N_W-1:0]  d_rem_v_next [DIV_STAGES];
    logic [VAL_Q_W-1:0]  d_q_v_next   [DIV_STAGES];
    logic [OFFSET_W-1:0] d_off_next   [DIV_STAGES];

    // Segment stage
    logic                c_valid_reg;
    seg_t                c_seg_reg;
    logic [RAMP_K_W-1:0] c_k_reg;
    logic [COLOR_W-1:0]  c_v_reg;
    logic [OFFSET_W-1:0] c_off_reg;
    seg_t                c_seg_next;
    logic [RAMP_K_W-1:0] c_k_next;
    logic [COLOR_W-1:0]  c_v_next;

    // Ramp numerator stage
    logic                n_valid_reg;
    seg_t                n_seg_reg;
    logic [RAMP_N_W-1:0] n_val_reg;
    logic [COLOR_W-1:0]  n_v_reg;
    logic [OFFSET_W-1:0] n_off_reg;

    // Reciprocal product stage
    logic                p_valid_reg;
    seg_t                p_seg_reg;
    logic [PROD_W-1:0]   p_prod_reg;
    logic [COLOR_W-1:0]  p_v_reg;
    logic [OFFSET_W-1:0] p_off_reg;

    // Output register
    logic                out_valid_reg;
    logic [OFFSET_W-1:0] out_off_reg;
    logic [COLOR_W-1:0]  out_r_reg;
    logic [COLOR_W-1:0]  out_g_reg;
    logic [COLOR_W-1:0]  out_b_reg;
    logic [COLOR_W-1:0]  out_r_next;
    logic [COLOR_W-1:0]  out_g_next;
    logic [COLOR_W-1:0]  out_b_next;
    logic [COLOR_W-1:0]  ramp;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            line_pitch_reg   <= PITCH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[DIM_W-1:0];
                CFG_LINE_PITCH:   line_pitch_reg   <= cfg_wr_data[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_eff = eff_dim(frame_width_reg);
    assign h_eff = eff_dim(frame_height_reg);

    // Advance the whole pipeline unless a result at the output is held by m_ready low
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = !skid_valid_reg;

    // Pick the skid beat first, else the incoming beat
    always_comb begin
        src_valid = skid_valid_reg || s_valid;
        src_x     = skid_valid_reg ? skid_x_reg : s_pixel_x;
        src_y     = skid_valid_reg ? skid_y_reg : s_pixel_y;
    end

    // Hold a beat in the skid while the pipeline is frozen
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_valid && s_ready) begin
            skid_x_reg <= s_pixel_x;
            skid_y_reg <= s_pixel_y;
        end
    end

    // Clamp coordinates to the frame
    always_comb begin
        s1_x_next = src_x;
        s1_y_next = src_y;
        if ({1'b0, src_x} >= w_eff) begin
            s1_x_next = COORD_W'(w_eff - DIM_W'(1));
        end
        if ({1'b0, src_y} >= h_eff) begin
            s1_y_next = COORD_W'(h_eff - DIM_W'(1));
        end
    end

    // Offset of the pixel: 4*(row + x), wrapping at the field width
    assign row_sum = s2_row_reg + ROW_W'(s2_x_reg);

    // Restoring division, one quotient bit per stage (value divider from the second stage)
    always_comb begin
        logic [HUE_N_W-1:0]  rh;
        logic [HUE_N_W-1:0]  dh;
        logic [HUE_Q_W-1:0]  qh;
        logic [VAL_N_W-1:0]  rv;
        logic [VAL_N_W-1:0]  dv;
        logic [VAL_Q_W-1:0]  qv;
        logic [OFFSET_W-1:0] off;
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (i == 0) begin
                rh  = s2_hn_reg;
                qh  = '0;
                rv  = s2_vn_reg;
                qv  = '0;
                off = OFFSET_W'({row_sum, 2'b00});
            end else begin
                rh  = d_rem_h_reg[i-1];
                qh  = d_q_h_reg[i-1];
                rv  = d_rem_v_reg[i-1];
                qv  = d_q_v_reg[i-1];
                off = d_off_reg[i-1];
            end
            dh = HUE_N_W'(w_eff) << (DIV_STAGES - 1 - i);
            if (rh >= dh) begin
                rh = rh - dh;
                qh = {qh[HUE_Q_W-2:0], 1'b1};
            end else begin
                qh = {qh[HUE_Q_W-2:0], 1'b0};
            end
            // The value quotient has one bit less: skip the first stage
            if (i >= 1) begin
                dv = VAL_N_W'(h_eff) << (DIV_STAGES - 1 - i);
                if (rv >= dv) begin
                    rv = rv - dv;
                    qv = {qv[VAL_Q_W-2:0], 1'b1};
                end else begin
                    qv = {qv[VAL_Q_W-2:0], 1'b0};
                end
            end
            d_rem_h_next[i] = rh;
            d_q_h_next[i]   = qh;
            d_rem_v_next[i] = rv;
            d_q_v_next[i]   = qv;
            d_off_next[i]   = off;
        end
    end

    // Find the hue segment and its ramp step
    always_comb begin
        logic [HUE_Q_W-1:0] h;
        h        = d_q_h_reg[DIV_STAGES-1];
        c_v_next = COLOR_W'(VAL_MAX) - d_q_v_reg[DIV_STAGES-1];
        if (h < HUE_Q_W'(SEG_1)) begin
            c_seg_next = SEG_RED_GREEN_UP;
            c_k_next   = RAMP_K_W'(h);
        end else if (h < HUE_Q_W'(SEG_2)) begin
            c_seg_next = SEG_GREEN_RED_DOWN;
            c_k_next   = RAMP_K_W'(HUE_Q_W'(SEG_2) - h);
        end else if (h < HUE_Q_W'(SEG_3)) begin
            c_seg_next = SEG_GREEN_BLUE_UP;
            c_k_next   = RAMP_K_W'(h - HUE_Q_W'(SEG_2));
        end else if (h < HUE_Q_W'(SEG_4)) begin
            c_seg_next = SEG_BLUE_GREEN_DOWN;
            c_k_next   = RAMP_K_W'(HUE_Q_W'(SEG_4) - h);
        end else if (h < HUE_Q_W'(SEG_5)) begin
            c_seg_next = SEG_BLUE_RED_UP;
            c_k_next   = RAMP_K_W'(h - HUE_Q_W'(SEG_4));
        end else begin
            c_seg_next = SEG_RED_BLUE_DOWN;
            c_k_next   = RAMP_K_W'(HUE_Q_W'(HUE_SPAN) - h);
        end
    end

    // Route full value and ramp to the channels
    assign ramp = p_prod_reg[RECIP_SHIFT +: COLOR_W];

    always_comb begin
        out_r_next = '0;
        out_g_next = '0;
        out_b_next = '0;
        case (p_seg_reg)
            SEG_RED_GREEN_UP: begin
                out_r_next = p_v_reg;
                out_g_next = ramp;
            end
            SEG_GREEN_RED_DOWN: begin
                out_r_next = ramp;
                out_g_next = p_v_reg;
            end
            SEG_GREEN_BLUE_UP: begin
                out_g_next = p_v_reg;
                out_b_next = ramp;
            end
            SEG_BLUE_GREEN_DOWN: begin
                out_g_next = ramp;
                out_b_next = p_v_reg;
            end
            SEG_BLUE_RED_UP: begin
                out_r_next = ramp;
                out_b_next = p_v_reg;
            end
            SEG_RED_BLUE_DOWN: begin
                out_r_next = p_v_reg;
                out_b_next = ramp;
            end
            default: ;
        endcase
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++) begin
                d_valid_reg[i] <= 1'b0;
            end
            c_valid_reg   <= 1'b0;
            n_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= src_valid;
            s2_valid_reg <= s1_valid_reg;
            d_valid_reg[0] <= s2_valid_reg;
            for (int i = 1; i < DIV_STAGES; i++) begin
                d_valid_reg[i] <= d_valid_reg[i-1];
            end
            c_valid_reg   <= d_valid_reg[DIV_STAGES-1];
            n_valid_reg   <= c_valid_reg;
            p_valid_reg   <= n_valid_reg;
            out_valid_reg <= p_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_x_reg   <= s1_x_next;
            s1_y_reg   <= s1_y_next;
            s2_hn_reg  <= HUE_N_W'(s1_x_reg) * HUE_N_W'(HUE_SPAN);
            s2_vn_reg  <= VAL_N_W'(s1_y_reg) * VAL_N_W'(VAL_MAX);
            s2_row_reg <= ROW_W'(s1_y_reg) * ROW_W'(line_pitch_reg);
            s2_x_reg   <= s1_x_reg;
            for (int i = 0; i < DIV_STAGES; i++) begin
                d_rem_h_reg[i] <= d_rem_h_next[i];
                d_q_h_reg[i]   <= d_q_h_next[i];
                d_rem_v_reg[i] <= d_rem_v_next[i];
                d_q_v_reg[i]   <= d_q_v_next[i];
                d_off_reg[i]   <= d_off_next[i];
            end
            c_seg_reg   <= c_seg_next;
            c_k_reg     <= c_k_next;
            c_v_reg     <= c_v_next;
            c_off_reg   <= d_off_reg[DIV_STAGES-1];
            n_seg_reg   <= c_seg_reg;
            n_val_reg   <= RAMP_N_W'(c_v_reg) * RAMP_N_W'(c_k_reg);
            n_v_reg     <= c_v_reg;
            n_off_reg   <= c_off_reg;
            p_seg_reg   <= n_seg_reg;
            p_prod_reg  <= PROD_W'(n_val_reg) * PROD_W'(RECIP_60);
            p_v_reg     <= n_v_reg;
            p_off_reg   <= n_off_reg;
            out_off_reg <= p_off_reg;
            out_r_reg   <= out_r_next;
            out_g_reg   <= out_g_next;
            out_b_reg   <= out_b_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_byte_offset = out_off_reg;
    assign m_red         = out_r_reg;
    assign m_green       = out_g_reg;
    assign m_blue        = out_b_reg;

`ifndef SYNTHESIS
    // A full skid drains on the first cycle the pipeline moves
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && en |=> !skid_valid_reg)
        else $error("skid beat not drained");

    // Clamped column lies inside the frame
    a_x_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> ({1'b0, s1_x_reg} < w_eff))
        else $error("column not clamped");

    // Hue leaving the divider is below a full turn
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid_reg[DIV_STAGES-1] |-> (d_q_h_reg[DIV_STAGES-1] < HUE_Q_W'(HUE_SPAN)))
        else $error("hue out of range");

    // Full saturation: one channel is always off
    a_one_channel_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red == '0 || m_green == '0 || m_blue == '0))
        else $error("no channel off");

    // A result appears only after the last internal stage held one
    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(p_valid_reg))
        else $error("result without source");
`endif

endmodule
